// File: hw/rtl/ltst_pkg.sv
`timescale 1ns / 1ps

package ltst_pkg;

  // Number of time zones carried by a tick.
  localparam int unsigned ZONES = 2;

  // Stream payload widths, rounded up to whole bytes.
  localparam int unsigned IN_FIELD_BITS  = 8 + 16 + ZONES;
  localparam int unsigned IN_DATA_W      = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_FIELD_BITS = 8 + 8 + 2;
  localparam int unsigned OUT_DATA_W     = ((OUT_FIELD_BITS + 7) / 8) * 8;

  // Configuration port geometry.
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_ON     = 2'd1,
    MODE_OFF    = 2'd2,
    MODE_REPORT = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    DET_TOLERANCE = 2'd0,
    DET_ABOVE     = 2'd1,
    DET_BELOW     = 2'd2
  } detect_e;

  // Register word indexes (byte address divided by four).
  localparam logic [2:0] REG_SENSOR_GROUP    = 3'd0;
  localparam logic [2:0] REG_SWITCH_GROUP    = 3'd1;
  localparam logic [2:0] REG_THRESHOLD       = 3'd2;
  localparam logic [2:0] REG_TRIGGER_ON_RISE = 3'd3;
  localparam logic [2:0] REG_SHUTTER_GROUP   = 3'd4;
  localparam logic [2:0] REG_TARGET_POSITION = 3'd5;
  localparam logic [2:0] REG_HOLD_SECONDS    = 3'd6;

  localparam logic [7:0]  NO_SENSOR         = 8'hFF;
  localparam logic [15:0] NO_BRIGHTNESS     = 16'hFFFF;
  localparam logic [15:0] HOLD_SECONDS_RST  = 16'd900;

endpackage

// File: hw/rtl/light_threshold_shutter_trigger.sv
`timescale 1ns / 1ps

// Light threshold shutter trigger.
//
// Input events arrive as stream transactions on the s_axis channel: tuser
// carries the event kind (second tick, group on, group off, brightness
// report) and tdata carries the group number, the brightness value and the
// time-zone match bits. Every input transaction produces exactly one result
// transaction on m_axis: tuser flags an emitted shutter position command,
// tdata carries the command group and position (zero when nothing is sent)
// and the detection status after the event.
//
// An input register and a result register hold the decision logic between
// them. A result is presented once its input transaction reaches the result
// register, and one transaction is accepted every cycle while the receiver
// takes results. The state (enable flag, last brightness, hold counter,
// detection, sent-once flag) is updated as an item moves into the result
// register. When the receiver stalls, the result register holds and the input
// register fills; s_axis_tready then drops until the result is taken. Reset
// empties both registers and restores the configuration and state defaults.
// The APB port reaches the seven registers at byte addresses 0 to 24; the user
// must write it only while no transactions are in flight; this is not enforced.

module light_threshold_shutter_trigger (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input events
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata from bit 0: group[7:0], brightness_value[15:0], zone_match[ZONES-1:0]
  input  logic [ltst_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // tuser from bit 0: mode[1:0]
  input  logic [1:0]                         s_axis_tuser,
  // Results
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata from bit 0: cmd_group[7:0], cmd_position[7:0], detect_status[1:0]
  output logic [ltst_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // tuser from bit 0: send
  output logic                               m_axis_tuser,
  // Configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ltst_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [ltst_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [ltst_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready
);
  import ltst_pkg::*;

  // Configuration registers
  logic [7:0]  sensor_group_q;
  logic [7:0]  switch_group_q;
  logic [15:0] threshold_q;
  logic        trigger_on_rise_q;
  logic [7:0]  shutter_group_q;
  logic [7:0]  target_position_q;
  logic [15:0] hold_seconds_q;

  // Automation state
  logic        auto_enabled_q, auto_enabled_d;
  logic [15:0] last_brightness_q, last_brightness_d;
  logic [15:0] hold_counter_q, hold_counter_d;
  logic [1:0]  detection_q, detection_d;
  logic        already_sent_q, already_sent_d;

  // Input register
  logic             in_valid_q;
  mode_e            in_mode_q;
  logic [7:0]       in_group_q;
  logic [15:0]      in_bright_q;
  logic [ZONES-1:0] in_zone_q;

  // Result register
  logic       out_valid_q;
  logic       out_send_q, out_send_d;
  logic [7:0] out_group_q, out_group_d;
  logic [7:0] out_pos_q, out_pos_d;
  logic [1:0] out_det_q;

  logic advance_w;
  logic load_w;
  logic cfg_wr_w;
  logic [2:0] reg_idx_w;

  // The result register can take a new item when it is empty or being drained.
  assign advance_w     = !out_valid_q || m_axis_tready;
  assign load_w        = in_valid_q && advance_w;
  assign s_axis_tready = !in_valid_q || advance_w;

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_wr_w  = psel && penable && pwrite && pready;
  assign reg_idx_w = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sensor_group_q    <= NO_SENSOR;
      switch_group_q    <= 8'd0;
      threshold_q       <= 16'd0;
      trigger_on_rise_q <= 1'b1;
      shutter_group_q   <= 8'd0;
      target_position_q <= 8'd0;
      hold_seconds_q    <= HOLD_SECONDS_RST;
    end else if (cfg_wr_w) begin
      unique case (reg_idx_w)
        REG_SENSOR_GROUP:    sensor_group_q    <= pwdata[7:0];
        REG_SWITCH_GROUP:    switch_group_q    <= pwdata[7:0];
        REG_THRESHOLD:       threshold_q       <= pwdata[15:0];
        REG_TRIGGER_ON_RISE: trigger_on_rise_q <= pwdata[0];
        REG_SHUTTER_GROUP:   shutter_group_q   <= pwdata[7:0];
        REG_TARGET_POSITION: target_position_q <= pwdata[7:0];
        REG_HOLD_SECONDS:    hold_seconds_q    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_w)
      REG_SENSOR_GROUP:    prdata = {24'd0, sensor_group_q};
      REG_SWITCH_GROUP:    prdata = {24'd0, switch_group_q};
      REG_THRESHOLD:       prdata = {16'd0, threshold_q};
      REG_TRIGGER_ON_RISE: prdata = {31'd0, trigger_on_rise_q};
      REG_SHUTTER_GROUP:   prdata = {24'd0, shutter_group_q};
      REG_TARGET_POSITION: prdata = {24'd0, target_position_q};
      REG_HOLD_SECONDS:    prdata = {16'd0, hold_seconds_q};
      default:             prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_mode_q   <= mode_e'(s_axis_tuser);
      in_group_q  <= s_axis_tdata[7:0];
      in_bright_q <= s_axis_tdata[23:8];
      in_zone_q   <= s_axis_tdata[24 +: ZONES];
    end
  end

  // ---------------------------------------------------------------------------
  // Decision logic
  // ---------------------------------------------------------------------------
  logic in_zone_w;
  logic no_sensor_w;
  logic hit_w;
  logic send_zone_w;
  logic send_hold_w;
  logic sent_mid_w;
  logic [15:0] count_mid_w;

  // All zone match bits are ORed together, and any match means "inside".
  assign in_zone_w   = |in_zone_q;
  assign no_sensor_w = (sensor_group_q == NO_SENSOR);
  assign hit_w       = trigger_on_rise_q ? (last_brightness_q > threshold_q)
                                         : (last_brightness_q < threshold_q);

  always_comb begin
    auto_enabled_d    = auto_enabled_q;
    last_brightness_d = last_brightness_q;
    hold_counter_d    = hold_counter_q;
    detection_d       = detection_q;
    already_sent_d    = already_sent_q;
    send_zone_w       = 1'b0;
    send_hold_w       = 1'b0;
    sent_mid_w        = already_sent_q;
    count_mid_w       = hold_counter_q;

    case (in_mode_q)
      MODE_ON: begin
        if (in_group_q == switch_group_q) auto_enabled_d = 1'b1;
      end
      MODE_OFF: begin
        if (in_group_q == switch_group_q) auto_enabled_d = 1'b0;
      end
      MODE_REPORT: begin
        if (!no_sensor_w && in_group_q == sensor_group_q) last_brightness_d = in_bright_q;
      end
      default: begin
        if (auto_enabled_q) begin
          if (in_zone_w) begin
            if (no_sensor_w) begin
              // Without a sensor the command goes out on the first zone tick.
              send_zone_w = !already_sent_q;
              sent_mid_w  = 1'b1;
            end else if (last_brightness_q != NO_BRIGHTNESS) begin
              if (hit_w) begin
                count_mid_w = hold_counter_q + 16'd1;
                detection_d = trigger_on_rise_q ? DET_ABOVE : DET_BELOW;
              end else begin
                count_mid_w = 16'd0;
                detection_d = DET_TOLERANCE;
              end
            end
          end else begin
            sent_mid_w = 1'b0;
          end
          hold_counter_d = count_mid_w;
          already_sent_d = sent_mid_w;
          if (count_mid_w == hold_seconds_q) begin
            send_hold_w    = !sent_mid_w;
            already_sent_d = 1'b1;
            hold_counter_d = 16'd0;
          end
        end
      end
    endcase

    out_send_d  = send_zone_w || send_hold_w;
    out_group_d = out_send_d ? shutter_group_q : 8'd0;
    out_pos_d   = out_send_d ? target_position_q : 8'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_enabled_q    <= 1'b1;
      last_brightness_q <= NO_BRIGHTNESS;
      hold_counter_q    <= 16'd0;
      detection_q       <= DET_TOLERANCE;
      already_sent_q    <= 1'b0;
    end else if (load_w) begin
      auto_enabled_q    <= auto_enabled_d;
      last_brightness_q <= last_brightness_d;
      hold_counter_q    <= hold_counter_d;
      detection_q       <= detection_d;
      already_sent_q    <= already_sent_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance_w) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_w) begin
      out_send_q  <= out_send_d;
      out_group_q <= out_group_d;
      out_pos_q   <= out_pos_d;
      out_det_q   <= detection_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_send_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - OUT_FIELD_BITS){1'b0}},
                          out_det_q, out_pos_q, out_group_q};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // A pending command result means the sent-once flag is already set; the
  // state cannot move on while the result waits.
  a_send_marks_sent: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_send_q) |-> already_sent_q
  ) else $error("command result pending while sent-once flag is clear");

  // The detection state only ever takes one of its three meaningful codes.
  a_detect_code: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    detection_q != 2'd3
  ) else $error("detection state holds an unused code");

  // With automation disabled, a tick leaves the hold counter alone.
  a_disabled_tick_holds: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (load_w && in_mode_q == MODE_TICK && !auto_enabled_q) |=> $stable(hold_counter_q)
  ) else $error("hold counter changed on a tick while disabled");

  // A stalled result register must not let the state advance.
  a_no_update_on_stall: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> $stable(already_sent_q) && $stable(hold_counter_q)
  ) else $error("state advanced while the result was stalled");

endmodule
